FILE: hdl/elc_pkg.sv
package elc_pkg;

	localparam int ELC_STACK_DEPTH = 64;

	// token codes as reported in found_token
	typedef enum logic [2:0] {
		TK_NONE  = 3'd0,
		TK_PLUS  = 3'd1,
		TK_TIMES = 3'd2,
		TK_LP    = 3'd3,
		TK_RP    = 3'd4,
		TK_DOL   = 3'd5,
		TK_ID    = 3'd6
	} tok_t;

	// grammar symbols held on the parse stack
	typedef enum logic [2:0] {
		SY_S   = 3'd0,
		SY_E   = 3'd1,
		SY_EP  = 3'd2,
		SY_T   = 3'd3,
		SY_TP  = 3'd4,
		SY_F   = 3'd5,
		SY_RP  = 3'd6,
		SY_DOL = 3'd7
	} sym_t;

	typedef enum logic [2:0] {
		ST_EMPTY = 3'd0,
		ST_BUSY  = 3'd1,
		ST_SYN   = 3'd2,
		ST_ACC   = 3'd3,
		ST_TRAIL = 3'd4,
		ST_DEEP  = 3'd5,
		ST_LEX   = 3'd6
	} line_st_t;

	typedef enum logic [2:0] {
		VD_ACCEPT = 3'd0,
		VD_SYNTAX = 3'd1,
		VD_LEXICAL = 3'd2,
		VD_EMPTY  = 3'd3,
		VD_TRAIL  = 3'd4,
		VD_DEEP   = 3'd5
	} verdict_t;

	// expected-set bits, one per token
	localparam logic [5:0] M_PLUS  = 6'b000001;
	localparam logic [5:0] M_TIMES = 6'b000010;
	localparam logic [5:0] M_LP    = 6'b000100;
	localparam logic [5:0] M_RP    = 6'b001000;
	localparam logic [5:0] M_DOL   = 6'b010000;
	localparam logic [5:0] M_ID    = 6'b100000;

	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_TIMES = 8'd42;
	localparam logic [7:0] CH_LP    = 8'd40;
	localparam logic [7:0] CH_RP    = 8'd41;
	localparam logic [7:0] CH_DOL   = 8'd36;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_NL    = 8'd10;

	// what the sequencer does after a byte or a token is handled
	typedef enum logic [1:0] {
		NK_TOKEN   = 2'd0,
		NK_VERDICT = 2'd1,
		NK_IDLE    = 2'd2
	} next_kind_t;

	typedef struct packed {
		logic accept;
		logic lex;
		logic take;
		logic emit;
		logic parse;
		logic load;
		logic finish;
	} elc_cmd_t;

	typedef struct packed {
		next_kind_t next_kind;
		logic       emit_parse;
		logic       more;
		logic       load;
		logic       out_busy;
	} elc_sts_t;

endpackage

FILE: hdl/elc_dp.sv
module elc_dp
	import elc_pkg::*;
#(
	parameter int STACK_DEPTH = ELC_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  elc_cmd_t    cmd,
	output elc_sts_t    sts,
	input  logic [7:0]  char_in,
	input  logic        last_in,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [2:0]  out_verdict,
	output logic [2:0]  out_found,
	output logic [5:0]  out_mask
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int IW  = $clog2(STACK_DEPTH);

	logic [7:0]     char_q;
	logic           last_q;
	logic           in_id_q;
	logic           pend_id_q;
	tok_t           pend_ch_q;
	tok_t           tok_q;
	line_st_t       status_q;
	tok_t           err_tok_q;
	logic [5:0]     err_mask_q;
	sym_t           top_q;
	logic [SPW-1:0] sp_q;
	sym_t           rd_q;
	sym_t           stack_mem [STACK_DEPTH];

	logic           out_valid_q;
	logic [2:0]     verdict_q;
	logic [2:0]     found_q;
	logic [5:0]     mask_q;

	// lexer decode
	logic is_lower, is_digit, is_alnum, is_skip;
	tok_t char_tok;
	logic id_end, id_cont, flag_after;

	always_comb begin
		is_lower = (char_q >= 8'd97) && (char_q <= 8'd122);
		is_digit = (char_q >= 8'd48) && (char_q <= 8'd57);
		is_alnum = is_lower || is_digit;
		is_skip  = (char_q == CH_SPACE) || (char_q == CH_NL);
		case (char_q)
			CH_PLUS:  char_tok = TK_PLUS;
			CH_TIMES: char_tok = TK_TIMES;
			CH_LP:    char_tok = TK_LP;
			CH_RP:    char_tok = TK_RP;
			CH_DOL:   char_tok = TK_DOL;
			default:  char_tok = TK_NONE;
		endcase
		id_end     = in_id_q && !is_alnum;
		id_cont    = in_id_q && is_alnum;
		flag_after = id_cont || (!in_id_q && is_lower);
	end

	// one step of the ll(1) table
	typedef enum logic [2:0] {
		A_EXP_MORE,
		A_EXP_RET,
		A_POP_MORE,
		A_POP_RET,
		A_FAIL
	} act_t;

	act_t       act;
	sym_t       sym_lo, sym_hi;
	logic [5:0] fail_mask;
	logic       starts, is_exp, is_pop, full;
	logic [SPW-1:0] sp_m1, sp_m2;

	always_comb begin
		act       = A_FAIL;
		sym_lo    = SY_S;
		sym_hi    = SY_S;
		fail_mask = 6'd0;
		starts    = (tok_q == TK_ID) || (tok_q == TK_LP);
		unique case (top_q)
			SY_S: begin
				if (starts) begin
					act = A_EXP_MORE; sym_lo = SY_DOL; sym_hi = SY_E;
				end else fail_mask = M_ID | M_LP;
			end
			SY_E: begin
				if (starts) begin
					act = A_EXP_MORE; sym_lo = SY_EP; sym_hi = SY_T;
				end else fail_mask = M_ID | M_LP;
			end
			SY_T: begin
				if (starts) begin
					act = A_EXP_MORE; sym_lo = SY_TP; sym_hi = SY_F;
				end else fail_mask = M_ID | M_LP;
			end
			SY_EP: begin
				if (tok_q == TK_PLUS) begin
					act = A_EXP_RET; sym_lo = SY_EP; sym_hi = SY_T;
				end else if (tok_q == TK_RP || tok_q == TK_DOL) act = A_POP_MORE;
				else fail_mask = M_PLUS | M_RP | M_DOL;
			end
			SY_TP: begin
				if (tok_q == TK_TIMES) begin
					act = A_EXP_RET; sym_lo = SY_TP; sym_hi = SY_F;
				end else if (tok_q == TK_PLUS || tok_q == TK_RP || tok_q == TK_DOL) begin
					act = A_POP_MORE;
				end else fail_mask = M_PLUS | M_TIMES | M_RP | M_DOL;
			end
			SY_F: begin
				if (tok_q == TK_ID) act = A_POP_RET;
				else if (tok_q == TK_LP) begin
					act = A_EXP_RET; sym_lo = SY_RP; sym_hi = SY_E;
				end else fail_mask = M_ID | M_LP;
			end
			SY_RP: begin
				if (tok_q == TK_RP) act = A_POP_RET;
				else fail_mask = M_RP;
			end
			SY_DOL: begin
				if (tok_q == TK_DOL) act = A_POP_RET;
				else fail_mask = M_DOL;
			end
		endcase
		is_exp = (act == A_EXP_MORE) || (act == A_EXP_RET);
		is_pop = (act == A_POP_MORE) || (act == A_POP_RET);
		full   = sp_q >= SPW'(STACK_DEPTH);
		sp_m1  = sp_q - SPW'(1);
		sp_m2  = sp_q - SPW'(2);
	end

	always_comb begin
		if (pend_id_q || pend_ch_q != TK_NONE) sts.next_kind = NK_TOKEN;
		else if (last_q) sts.next_kind = (status_q == ST_BUSY) ? NK_TOKEN : NK_VERDICT;
		else sts.next_kind = NK_IDLE;
		sts.emit_parse = (status_q == ST_EMPTY) || (status_q == ST_BUSY);
		sts.more       = ((act == A_EXP_MORE) && !full) || (act == A_POP_MORE);
		// a pop that leaves entries behind must refetch the new top
		sts.load       = is_pop && (sp_q != SPW'(1));
		sts.out_busy   = out_valid_q && !out_ready;
	end

	// stack body below the cached top
	always_ff @(posedge clk) begin
		if (cmd.parse && is_exp && !full) stack_mem[sp_m1[IW-1:0]] <= sym_lo;
		rd_q <= stack_mem[sp_m2[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) char_q <= char_in;
		if (cmd.take) begin
			if (pend_id_q) tok_q <= TK_ID;
			else tok_q <= pend_ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= 1'b0;
			in_id_q    <= 1'b0;
			pend_id_q  <= 1'b0;
			pend_ch_q  <= TK_NONE;
			status_q   <= ST_EMPTY;
			err_tok_q  <= TK_NONE;
			err_mask_q <= 6'd0;
			top_q      <= SY_S;
			sp_q       <= SPW'(1);
		end else begin
			if (cmd.accept) last_q <= last_in;
			if (cmd.lex && status_q != ST_LEX) begin
				pend_id_q <= id_end || (last_q && flag_after);
				in_id_q   <= flag_after && !last_q;
				if (!id_cont && !is_lower) begin
					if (char_tok != TK_NONE) pend_ch_q <= char_tok;
					else if (!is_skip) status_q <= ST_LEX;
				end
			end
			if (cmd.take) begin
				if (pend_id_q) pend_id_q <= 1'b0;
				else pend_ch_q <= TK_NONE;
			end
			if (cmd.emit) begin
				if (status_q == ST_EMPTY) status_q <= ST_BUSY;
				else if (status_q == ST_ACC) status_q <= ST_TRAIL;
			end
			if (cmd.parse) begin
				if (is_exp) begin
					if (full) status_q <= ST_DEEP;
					else begin
						top_q <= sym_hi;
						sp_q  <= sp_q + SPW'(1);
					end
				end else if (is_pop) begin
					sp_q <= sp_m1;
					if (top_q == SY_DOL && sp_q == SPW'(1)) status_q <= ST_ACC;
				end else begin
					status_q   <= ST_SYN;
					err_tok_q  <= tok_q;
					err_mask_q <= fail_mask;
				end
			end
			if (cmd.load) top_q <= rd_q;
			if (cmd.finish) begin
				last_q     <= 1'b0;
				in_id_q    <= 1'b0;
				pend_id_q  <= 1'b0;
				pend_ch_q  <= TK_NONE;
				status_q   <= ST_EMPTY;
				err_tok_q  <= TK_NONE;
				err_mask_q <= 6'd0;
				top_q      <= SY_S;
				sp_q       <= SPW'(1);
			end
		end
	end

	// result register
	verdict_t vd;
	always_comb begin
		unique case (status_q)
			ST_LEX:   vd = VD_LEXICAL;
			ST_EMPTY: vd = VD_EMPTY;
			ST_SYN:   vd = VD_SYNTAX;
			ST_TRAIL: vd = VD_TRAIL;
			ST_DEEP:  vd = VD_DEEP;
			default:  vd = VD_ACCEPT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			verdict_q <= vd;
			found_q   <= (status_q == ST_SYN) ? err_tok_q : TK_NONE;
			mask_q    <= (status_q == ST_SYN) ? err_mask_q : 6'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = verdict_q;
	assign out_found   = found_q;
	assign out_mask    = mask_q;

endmodule

FILE: hdl/elc_ctrl.sv
module elc_ctrl
	import elc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  elc_sts_t sts,
	output elc_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEX,
		S_NEXT,
		S_EMIT,
		S_PARSE,
		S_LOAD_MORE,
		S_LOAD_RET,
		S_VERDICT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == S_IDLE) && in_valid;
		cmd.lex    = (state_q == S_LEX);
		cmd.take   = (state_q == S_NEXT) && (sts.next_kind == NK_TOKEN);
		cmd.emit   = (state_q == S_EMIT);
		cmd.parse  = (state_q == S_PARSE);
		cmd.load   = (state_q == S_LOAD_MORE) || (state_q == S_LOAD_RET);
		cmd.finish = (state_q == S_VERDICT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_LEX;
				S_LEX: state_q <= S_NEXT;
				S_NEXT: begin
					unique case (sts.next_kind)
						NK_TOKEN:   state_q <= S_EMIT;
						NK_VERDICT: state_q <= S_VERDICT;
						default:    state_q <= S_IDLE;
					endcase
				end
				S_EMIT: state_q <= sts.emit_parse ? S_PARSE : S_NEXT;
				S_PARSE: begin
					if (sts.load) state_q <= sts.more ? S_LOAD_MORE : S_LOAD_RET;
					else state_q <= sts.more ? S_PARSE : S_NEXT;
				end
				S_LOAD_MORE: state_q <= S_PARSE;
				S_LOAD_RET: state_q <= S_NEXT;
				S_VERDICT: if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/expression_lexer_ll1_checker_core.sv
// sequence: a byte passes the accept, lex and dispatch states; each token then passes an emit state,
//   a dispatch state, its table steps in the parse state and a load step per pop that refetches the stack top
// line end adds the verdict state, held while the previous result waits; the result shows
//   in the output register in the cycle after it
// throughput: one byte at a time, set by the single shared parse-step unit and stack read port
// reset: arst_n clears the sequencer, line state and output valid; stack memory is not cleared
module expression_lexer_ll1_checker_core
	import elc_pkg::*;
#(
	parameter int STACK_DEPTH = ELC_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // line_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [2:0] verdict, [5:3] found_token, [11:6] expected_mask
);

	elc_cmd_t   cmd;
	elc_sts_t   sts;
	logic [2:0] verdict;
	logic [2:0] found_token;
	logic [5:0] expected_mask;

	elc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	elc_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.char_in     (s_axis_tdata),
		.last_in     (s_axis_tlast),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_verdict (verdict),
		.out_found   (found_token),
		.out_mask    (expected_mask)
	);

	assign m_axis_tdata = {4'd0, expected_mask, found_token, verdict};

endmodule

FILE: hdl/elc_checker.sv
module elc_checker
	import elc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a byte beat is worked on before the next one is taken
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken back to back");

	// a waiting beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= VD_DEEP && m_axis_tdata[15:12] == 4'd0)
		else $error("verdict code out of range");

	// detail fields only carry data on a syntax error
	a_detail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != VD_SYNTAX |-> m_axis_tdata[11:3] == 9'd0)
		else $error("detail fields set without syntax error");

	a_syntax_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == VD_SYNTAX
			|-> m_axis_tdata[11:6] != 6'd0 && m_axis_tdata[5:3] != 3'd7)
		else $error("syntax error without expected set");

endmodule

bind expression_lexer_ll1_checker_core elc_checker u_elc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
